[hdl/mesh_nearest_triangle_distance_assert.svh]
// ----------------------------------------------------------------------------
// Nearest triangle distance: assertion macros
// Implication checks on the block clock, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef MESH_NEAREST_TRIANGLE_DISTANCE_ASSERT_SVH
`define MESH_NEAREST_TRIANGLE_DISTANCE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define MNTD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mntd: same-cycle check failed");
`define MNTD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mntd: next-cycle check failed");
`else
`define MNTD_ASSERT_IMP(name, ante, cons)
`define MNTD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

[hdl/mntd_pkg.sv]
// ----------------------------------------------------------------------------
// mntd_pkg
// Widths, register indexes and helpers for the nearest triangle distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package mntd_pkg;

    localparam int MAX_TRIANGLES    = 4096;
    localparam int FRACTION_BITS    = 16;
    localparam int IDX_W            = $clog2(MAX_TRIANGLES);
    localparam int CNT_W            = IDX_W + 1;
    localparam int MUL_W            = 33;
    localparam int PROD_W           = 2 * MUL_W;
    localparam int POS_W            = 40;
    localparam int T_W              = FRACTION_BITS + 1;
    localparam int DCNT_W           = $clog2(T_W);
    localparam int SHIFT_W          = 6;
    localparam int DOT_LIMIT_BIT    = 30;
    localparam int ORIENT_LIMIT_BIT = 29;
    localparam int DEN_LIMIT_BIT    = 38;
    localparam int NUM_AXES         = 3;
    localparam int NUM_DOTS         = 6;
    localparam int CFG_IDX_W        = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_X        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Y        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_QUERY_Z        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIANGLE_COUNT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_COUNT   = 3'd4;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? 64'(-v) : 64'(v);
    endfunction

    function automatic logic [POS_W-1:0] mag_pos(input logic signed [POS_W-1:0] v);
        return v[POS_W-1] ? POS_W'(-v) : POS_W'(v);
    endfunction

endpackage

`default_nettype wire

[hdl/mesh_nearest_triangle_distance.sv]
// ----------------------------------------------------------------------------
// mesh_nearest_triangle_distance
// Brute-force nearest triangle: closest point per triangle, running minimum,
// square root and normal-signed distance once per query.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//  in      | in_valid / in_stall    | v0_x .. v2_z, normal_x .. normal_z
//  out     | out_valid / out_stall  | nearest_index, distance_squared,
//          |                        | unsigned_distance, signed_distance
//
//  One triangle is worked on one shared 33x33 multiplier: the six dot
//  products, the dot fit shift and the two weights (halving, then one
//  quotient bit a cycle); the last triangle of a query adds the square root
//  at one result bit a cycle and the load of the output register.
//  in_stall is high while a triangle is in work. A result waits in the output
//  register while the next triangle is taken. No clearing pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mesh_nearest_triangle_distance_assert.svh"

module mesh_nearest_triangle_distance
    import mntd_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [CFG_IDX_W-1:0]     cfg_index,
    input  logic [31:0]              cfg_data,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic signed [31:0]       v0_x,
    input  logic signed [31:0]       v0_y,
    input  logic signed [31:0]       v0_z,
    input  logic signed [31:0]       v1_x,
    input  logic signed [31:0]       v1_y,
    input  logic signed [31:0]       v1_z,
    input  logic signed [31:0]       v2_x,
    input  logic signed [31:0]       v2_y,
    input  logic signed [31:0]       v2_z,
    input  logic signed [31:0]       normal_x,
    input  logic signed [31:0]       normal_y,
    input  logic signed [31:0]       normal_z,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [IDX_W-1:0]         nearest_index,
    output logic [63:0]              distance_squared,
    output logic [31:0]              unsigned_distance,
    output logic signed [32:0]       signed_distance
);

    typedef enum logic [17:0] {
        S_IDLE      = 18'h00001,
        S_DOT       = 18'h00002,
        S_DFIT_INIT = 18'h00004,
        S_DFIT      = 18'h00008,
        S_DSCALE    = 18'h00010,
        S_VMUL      = 18'h00020,
        S_REGION    = 18'h00040,
        S_RPREP     = 18'h00080,
        S_RNORM     = 18'h00100,
        S_RDIV      = 18'h00200,
        S_CLOSE     = 18'h00400,
        S_DIST      = 18'h00800,
        S_OFIT_INIT = 18'h01000,
        S_OFIT      = 18'h02000,
        S_ORIENT    = 18'h04000,
        S_UPDATE    = 18'h08000,
        S_SQRT      = 18'h10000,
        S_EMIT      = 18'h20000
    } state_t;

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) <<< (FRACTION_BITS - 1);
    localparam logic [T_W-1:0]           T_ONE      = T_W'(1) << FRACTION_BITS;
    localparam logic [63:0]              SQRT_TOP   = 64'(1) << 62;

    // control
    state_t                    state_reg;
    logic                      ph_reg;
    logic [1:0]                ix_reg;
    logic [2:0]                jx_reg;
    logic                      slot_reg;
    logic [DCNT_W-1:0]         dcnt_reg;
    logic [CNT_W-1:0]          seen_reg;
    logic [63:0]               best_dist_reg;
    logic [IDX_W-1:0]          best_idx_reg;
    logic                      best_neg_reg;
    logic                      out_valid_reg;
    logic signed [31:0]        query_reg [NUM_AXES];
    logic [CNT_W-1:0]          tri_count_reg;
    logic [CNT_W-1:0]          norm_count_reg;

    // datapath
    logic signed [31:0]        vtx0_reg [NUM_AXES];
    logic signed [31:0]        vtx1_reg [NUM_AXES];
    logic signed [31:0]        vtx2_reg [NUM_AXES];
    logic signed [31:0]        nrm_reg  [NUM_AXES];
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [63:0]        d_reg [NUM_DOTS];
    logic signed [63:0]        v_reg [NUM_AXES];
    logic [63:0]               orv_reg;
    logic [SHIFT_W-1:0]        k_reg;
    logic signed [POS_W-1:0]   q_reg [NUM_AXES];
    logic                      e1_bc_reg;
    logic signed [63:0]        num_reg [2];
    logic signed [63:0]        den_reg [2];
    logic [63:0]               rn_reg;
    logic [63:0]               rd_reg;
    logic [T_W-1:0]            rq_reg;
    logic [T_W-1:0]            t_reg [2];
    logic [63:0]               dist_reg;
    logic                      sat_reg;
    logic signed [63:0]        orient_reg;
    logic [63:0]               sx_reg;
    logic [63:0]               sr_reg;
    logic [63:0]               sbit_reg;
    logic [IDX_W-1:0]          nearest_index_reg;
    logic [63:0]               distance_squared_reg;
    logic [31:0]               unsigned_distance_reg;
    logic signed [32:0]        signed_distance_reg;

    // combinational
    logic signed [32:0]        ab [NUM_AXES];
    logic signed [32:0]        ac [NUM_AXES];
    logic signed [32:0]        bc [NUM_AXES];
    logic signed [32:0]        ap [NUM_AXES];
    logic signed [32:0]        bp [NUM_AXES];
    logic signed [32:0]        cp [NUM_AXES];
    logic signed [POS_W-1:0]   ext_a [NUM_AXES];
    logic signed [POS_W-1:0]   ext_b [NUM_AXES];
    logic signed [POS_W-1:0]   ext_c [NUM_AXES];
    logic signed [POS_W-1:0]   off [NUM_AXES];
    logic signed [32:0]        dq [NUM_DOTS];
    logic [NUM_DOTS-1:0]       dot_fit_ok;
    logic                      dots_fit;
    logic signed [32:0]        dot_edge;
    logic signed [32:0]        dot_off;
    logic signed [MUL_W-1:0]   mul_a;
    logic signed [MUL_W-1:0]   mul_b;
    logic signed [63:0]        prod64;
    logic signed [PROD_W-1:0]  rnd_full;
    logic [POS_W-1:0]          off_mag;
    logic signed [POS_W-1:0]   off_sh;
    logic [64:0]               dist_sum;
    logic                      fit_high;
    logic signed [63:0]        w1, w2, w3, w4, w5, w6;
    logic signed [63:0]        vva, vvb, vvc;
    logic signed [63:0]        d43, d56, vsum;
    logic signed [63:0]        num_sel, den_sel;
    logic                      den_le0;
    logic                      den_big;
    logic                      div_ge;
    logic                      div_last;
    logic [T_W-1:0]            rq_shift;
    logic [63:0]               dist_final;
    logic                      take_new;
    logic [63:0]               best_new;
    logic [CNT_W-1:0]          seen_next;
    logic [CNT_W-1:0]          cnt_eff;
    logic                      query_done;
    logic [64:0]               sq_trial;
    logic                      sq_ge;
    logic                      emit_go;
    logic                      sign_neg;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    assign nearest_index     = nearest_index_reg;
    assign distance_squared  = distance_squared_reg;
    assign unsigned_distance = unsigned_distance_reg;
    assign signed_distance   = signed_distance_reg;

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_axis
        assign ab[g]    = {vtx1_reg[g][31], vtx1_reg[g]} - {vtx0_reg[g][31], vtx0_reg[g]};
        assign ac[g]    = {vtx2_reg[g][31], vtx2_reg[g]} - {vtx0_reg[g][31], vtx0_reg[g]};
        assign bc[g]    = {vtx2_reg[g][31], vtx2_reg[g]} - {vtx1_reg[g][31], vtx1_reg[g]};
        assign ap[g]    = {query_reg[g][31], query_reg[g]} - {vtx0_reg[g][31], vtx0_reg[g]};
        assign bp[g]    = {query_reg[g][31], query_reg[g]} - {vtx1_reg[g][31], vtx1_reg[g]};
        assign cp[g]    = {query_reg[g][31], query_reg[g]} - {vtx2_reg[g][31], vtx2_reg[g]};
        assign ext_a[g] = {{(POS_W-32){vtx0_reg[g][31]}}, vtx0_reg[g]};
        assign ext_b[g] = {{(POS_W-32){vtx1_reg[g][31]}}, vtx1_reg[g]};
        assign ext_c[g] = {{(POS_W-32){vtx2_reg[g][31]}}, vtx2_reg[g]};
        assign off[g]   = {{(POS_W-32){query_reg[g][31]}}, query_reg[g]} - q_reg[g];
    end

    for (genvar g = 0; g < NUM_DOTS; g++) begin : g_dot
        assign dq[g]         = d_reg[g][32:0];
        assign dot_fit_ok[g] = (&d_reg[g][63:DOT_LIMIT_BIT]) || !(|d_reg[g][63:DOT_LIMIT_BIT]);
    end
    assign dots_fit = &dot_fit_ok;

    assign w1  = d_reg[0];
    assign w2  = d_reg[1];
    assign w3  = d_reg[2];
    assign w4  = d_reg[3];
    assign w5  = d_reg[4];
    assign w6  = d_reg[5];
    assign vvc = v_reg[0];
    assign vvb = v_reg[1];
    assign vva = v_reg[2];
    assign d43  = w4 - w3;
    assign d56  = w5 - w6;
    assign vsum = vva + vvb + vvc;

    // shared multiplier operand select
    always_comb begin
        dot_edge = jx_reg[0] ? ac[ix_reg] : ab[ix_reg];
        case (jx_reg[2:1])
            2'd0:    dot_off = ap[ix_reg];
            2'd1:    dot_off = bp[ix_reg];
            2'd2:    dot_off = cp[ix_reg];
            default: dot_off = '0;
        endcase
        off_mag = mag_pos(off[ix_reg]);
        off_sh  = off[ix_reg] >>> k_reg;
        mul_a   = '0;
        mul_b   = '0;
        case (state_reg)
            S_DOT: begin
                mul_a = dot_edge >>> 2;
                mul_b = dot_off >>> 2;
            end
            S_VMUL: begin
                case (jx_reg)
                    3'd0:    begin mul_a = dq[0]; mul_b = dq[3]; end
                    3'd1:    begin mul_a = dq[2]; mul_b = dq[1]; end
                    3'd2:    begin mul_a = dq[4]; mul_b = dq[1]; end
                    3'd3:    begin mul_a = dq[0]; mul_b = dq[5]; end
                    3'd4:    begin mul_a = dq[2]; mul_b = dq[5]; end
                    3'd5:    begin mul_a = dq[4]; mul_b = dq[3]; end
                    default: begin mul_a = '0;    mul_b = '0;    end
                endcase
            end
            S_CLOSE: begin
                if (jx_reg[0])
                    mul_a = ac[ix_reg];
                else
                    mul_a = e1_bc_reg ? bc[ix_reg] : ab[ix_reg];
                mul_b = MUL_W'(t_reg[jx_reg[0]]);
            end
            S_DIST: begin
                mul_a = {1'b0, off_mag[31:0]};
                mul_b = {1'b0, off_mag[31:0]};
            end
            S_ORIENT: begin
                mul_a = off_sh[MUL_W-1:0];
                mul_b = {nrm_reg[ix_reg][31], nrm_reg[ix_reg]};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod64   = prod_reg[63:0];
    assign rnd_full = (prod_reg + ROUND_HALF) >>> FRACTION_BITS;
    assign dist_sum = {1'b0, dist_reg} + {1'b0, prod_reg[63:0]};

    assign fit_high = (state_reg == S_DFIT) ? (|orv_reg[63:DOT_LIMIT_BIT])
                                            : (|orv_reg[63:ORIENT_LIMIT_BIT]);

    // weight division
    assign num_sel  = num_reg[slot_reg];
    assign den_sel  = den_reg[slot_reg];
    assign den_le0  = den_sel[63] || (den_sel == 64'sd0);
    assign den_big  = |rd_reg[63:DEN_LIMIT_BIT];
    assign div_ge   = (rn_reg >= rd_reg);
    assign div_last = (dcnt_reg == DCNT_W'(FRACTION_BITS));
    assign rq_shift = {rq_reg[T_W-2:0], div_ge};

    // running minimum
    assign dist_final = sat_reg ? '1 : dist_reg;
    assign take_new   = (seen_reg == '0) || (dist_final < best_dist_reg);
    assign best_new   = take_new ? dist_final : best_dist_reg;
    assign seen_next  = seen_reg + 1'b1;
    always_comb begin
        if (tri_count_reg == '0)
            cnt_eff = CNT_W'(1);
        else if (tri_count_reg > CNT_W'(MAX_TRIANGLES))
            cnt_eff = CNT_W'(MAX_TRIANGLES);
        else
            cnt_eff = tri_count_reg;
    end
    assign query_done = (seen_next >= cnt_eff);

    assign sq_trial = {1'b0, sr_reg} + {1'b0, sbit_reg};
    assign sq_ge    = ({1'b0, sx_reg} >= sq_trial);

    assign emit_go  = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign sign_neg = ({1'b0, best_idx_reg} < norm_count_reg) && best_neg_reg;

    // sequencer and query state
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg      <= S_IDLE;
            ph_reg         <= 1'b0;
            ix_reg         <= '0;
            jx_reg         <= '0;
            slot_reg       <= 1'b0;
            dcnt_reg       <= '0;
            seen_reg       <= '0;
            best_dist_reg  <= '1;
            best_idx_reg   <= '0;
            best_neg_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            query_reg[0]   <= '0;
            query_reg[1]   <= '0;
            query_reg[2]   <= '0;
            tri_count_reg  <= CNT_W'(1);
            norm_count_reg <= '0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_QUERY_X:        query_reg[0]   <= cfg_data;
                    CFG_QUERY_Y:        query_reg[1]   <= cfg_data;
                    CFG_QUERY_Z:        query_reg[2]   <= cfg_data;
                    CFG_TRIANGLE_COUNT: tri_count_reg  <= cfg_data[CNT_W-1:0];
                    CFG_NORMAL_COUNT:   norm_count_reg <= cfg_data[CNT_W-1:0];
                    default:            ;
                endcase
            end

            if (out_valid_reg && !out_stall && !emit_go)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE: begin
                    if (in_valid) begin
                        state_reg <= S_DOT;
                        ph_reg    <= 1'b0;
                        ix_reg    <= '0;
                        jx_reg    <= '0;
                    end
                end
                S_DOT: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        if (ix_reg == 2'(NUM_AXES - 1)) begin
                            ix_reg <= '0;
                            if (jx_reg == 3'(NUM_DOTS - 1))
                                state_reg <= S_DFIT_INIT;
                            else
                                jx_reg <= jx_reg + 1'b1;
                        end else begin
                            ix_reg <= ix_reg + 1'b1;
                        end
                    end
                end
                S_DFIT_INIT: state_reg <= S_DFIT;
                S_DFIT: begin
                    if (!fit_high)
                        state_reg <= S_DSCALE;
                end
                S_DSCALE: begin
                    state_reg <= S_VMUL;
                    jx_reg    <= '0;
                    ph_reg    <= 1'b0;
                end
                S_VMUL: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        if (jx_reg == 3'(NUM_DOTS - 1))
                            state_reg <= S_REGION;
                        else
                            jx_reg <= jx_reg + 1'b1;
                    end
                end
                S_REGION: begin
                    slot_reg  <= 1'b0;
                    state_reg <= S_RPREP;
                end
                S_RPREP: begin
                    if (den_le0) begin
                        if (slot_reg) begin
                            state_reg <= S_CLOSE;
                            ix_reg    <= '0;
                            jx_reg    <= '0;
                            ph_reg    <= 1'b0;
                        end else begin
                            slot_reg <= 1'b1;
                        end
                    end else begin
                        state_reg <= S_RNORM;
                    end
                end
                S_RNORM: begin
                    if (!den_big) begin
                        state_reg <= S_RDIV;
                        dcnt_reg  <= '0;
                    end
                end
                S_RDIV: begin
                    if (div_last) begin
                        if (slot_reg) begin
                            state_reg <= S_CLOSE;
                            ix_reg    <= '0;
                            jx_reg    <= '0;
                            ph_reg    <= 1'b0;
                        end else begin
                            slot_reg  <= 1'b1;
                            state_reg <= S_RPREP;
                        end
                    end else begin
                        dcnt_reg <= dcnt_reg + 1'b1;
                    end
                end
                S_CLOSE: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        if (ix_reg == 2'(NUM_AXES - 1)) begin
                            ix_reg <= '0;
                            if (jx_reg[0])
                                state_reg <= S_DIST;
                            else
                                jx_reg <= jx_reg + 1'b1;
                        end else begin
                            ix_reg <= ix_reg + 1'b1;
                        end
                    end
                end
                S_DIST: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        if (ix_reg == 2'(NUM_AXES - 1)) begin
                            ix_reg    <= '0;
                            state_reg <= S_OFIT_INIT;
                        end else begin
                            ix_reg <= ix_reg + 1'b1;
                        end
                    end
                end
                S_OFIT_INIT: state_reg <= S_OFIT;
                S_OFIT: begin
                    if (!fit_high) begin
                        state_reg <= S_ORIENT;
                        ix_reg    <= '0;
                        ph_reg    <= 1'b0;
                    end
                end
                S_ORIENT: begin
                    ph_reg <= ~ph_reg;
                    if (ph_reg) begin
                        if (ix_reg == 2'(NUM_AXES - 1)) begin
                            ix_reg    <= '0;
                            state_reg <= S_UPDATE;
                        end else begin
                            ix_reg <= ix_reg + 1'b1;
                        end
                    end
                end
                S_UPDATE: begin
                    if (take_new) begin
                        best_dist_reg <= dist_final;
                        best_idx_reg  <= seen_reg[IDX_W-1:0];
                        best_neg_reg  <= orient_reg[63];
                    end
                    seen_reg  <= seen_next;
                    state_reg <= query_done ? S_SQRT : S_IDLE;
                end
                S_SQRT: begin
                    if (sbit_reg == 64'(1))
                        state_reg <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        out_valid_reg <= 1'b1;
                        best_dist_reg <= '1;
                        best_idx_reg  <= '0;
                        best_neg_reg  <= 1'b0;
                        seen_reg      <= '0;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk) begin
        prod_reg <= mul_a * mul_b;

        case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    vtx0_reg[0] <= v0_x;
                    vtx0_reg[1] <= v0_y;
                    vtx0_reg[2] <= v0_z;
                    vtx1_reg[0] <= v1_x;
                    vtx1_reg[1] <= v1_y;
                    vtx1_reg[2] <= v1_z;
                    vtx2_reg[0] <= v2_x;
                    vtx2_reg[1] <= v2_y;
                    vtx2_reg[2] <= v2_z;
                    nrm_reg[0]  <= normal_x;
                    nrm_reg[1]  <= normal_y;
                    nrm_reg[2]  <= normal_z;
                end
            end
            S_DOT: begin
                if (ph_reg)
                    d_reg[jx_reg] <= (ix_reg == '0) ? prod64 : d_reg[jx_reg] + prod64;
            end
            S_DFIT_INIT: begin
                orv_reg <= mag64(d_reg[0]) | mag64(d_reg[1]) | mag64(d_reg[2])
                         | mag64(d_reg[3]) | mag64(d_reg[4]) | mag64(d_reg[5]);
                k_reg   <= '0;
            end
            S_DFIT, S_OFIT: begin
                if (fit_high) begin
                    orv_reg <= orv_reg >> 1;
                    k_reg   <= k_reg + 1'b1;
                end
            end
            S_DSCALE: begin
                for (int i = 0; i < NUM_DOTS; i++)
                    d_reg[i] <= d_reg[i] >>> k_reg;
            end
            S_VMUL: begin
                if (ph_reg)
                    v_reg[jx_reg[2:1]] <= jx_reg[0] ? v_reg[jx_reg[2:1]] - prod64 : prod64;
            end
            S_REGION: begin
                num_reg[0] <= '0;
                den_reg[0] <= '0;
                num_reg[1] <= '0;
                den_reg[1] <= '0;
                e1_bc_reg  <= 1'b0;
                dist_reg   <= '0;
                sat_reg    <= 1'b0;
                orient_reg <= '0;
                for (int i = 0; i < NUM_AXES; i++)
                    q_reg[i] <= ext_a[i];
                if (w1 <= 0 && w2 <= 0) begin
                    // vertex a: both weights stay zero
                end else if (w3 >= 0 && w4 <= w3) begin
                    for (int i = 0; i < NUM_AXES; i++)
                        q_reg[i] <= ext_b[i];
                end else if (vvc <= 0 && w1 >= 0 && w3 <= 0) begin
                    num_reg[0] <= w1;
                    den_reg[0] <= w1 - w3;
                end else if (w6 >= 0 && w5 <= w6) begin
                    for (int i = 0; i < NUM_AXES; i++)
                        q_reg[i] <= ext_c[i];
                end else if (vvb <= 0 && w2 >= 0 && w6 <= 0) begin
                    num_reg[1] <= w2;
                    den_reg[1] <= w2 - w6;
                end else if (vva <= 0 && d43 >= 0 && d56 >= 0) begin
                    for (int i = 0; i < NUM_AXES; i++)
                        q_reg[i] <= ext_b[i];
                    e1_bc_reg  <= 1'b1;
                    num_reg[0] <= d43;
                    den_reg[0] <= d43 + d56;
                end else begin
                    num_reg[0] <= vvb;
                    den_reg[0] <= vsum;
                    num_reg[1] <= vvc;
                    den_reg[1] <= vsum;
                end
            end
            S_RPREP: begin
                if (den_le0) begin
                    t_reg[slot_reg] <= '0;
                end else begin
                    rd_reg <= den_sel;
                    if (num_sel[63])
                        rn_reg <= '0;
                    else if (num_sel > den_sel)
                        rn_reg <= den_sel;
                    else
                        rn_reg <= num_sel;
                end
                rq_reg <= '0;
            end
            S_RNORM: begin
                if (den_big) begin
                    rn_reg <= rn_reg >> 1;
                    rd_reg <= rd_reg >> 1;
                end
            end
            S_RDIV: begin
                rn_reg <= (div_ge ? rn_reg - rd_reg : rn_reg) << 1;
                rq_reg <= rq_shift;
                if (div_last)
                    t_reg[slot_reg] <= rq_shift;
            end
            S_CLOSE: begin
                if (ph_reg)
                    q_reg[ix_reg] <= q_reg[ix_reg] + rnd_full[POS_W-1:0];
            end
            S_DIST: begin
                if (ph_reg) begin
                    if (|off_mag[POS_W-1:32])
                        sat_reg <= 1'b1;
                    else if (dist_sum[64])
                        sat_reg <= 1'b1;
                    else
                        dist_reg <= dist_sum[63:0];
                end
            end
            S_OFIT_INIT: begin
                orv_reg <= 64'(mag_pos(off[0]) | mag_pos(off[1]) | mag_pos(off[2]));
                k_reg   <= '0;
            end
            S_ORIENT: begin
                if (ph_reg)
                    orient_reg <= orient_reg + prod64;
            end
            S_UPDATE: begin
                sx_reg   <= best_new;
                sr_reg   <= '0;
                sbit_reg <= SQRT_TOP;
            end
            S_SQRT: begin
                if (sq_ge) begin
                    sx_reg <= sx_reg - sq_trial[63:0];
                    sr_reg <= (sr_reg >> 1) + sbit_reg;
                end else begin
                    sr_reg <= sr_reg >> 1;
                end
                sbit_reg <= sbit_reg >> 2;
            end
            S_EMIT: begin
                if (emit_go) begin
                    nearest_index_reg     <= best_idx_reg;
                    distance_squared_reg  <= best_dist_reg;
                    unsigned_distance_reg <= sr_reg[31:0];
                    signed_distance_reg   <= sign_neg ? -$signed({1'b0, sr_reg[31:0]})
                                                      : $signed({1'b0, sr_reg[31:0]});
                end
            end
            default: ;
        endcase
    end

    `MNTD_ASSERT_NEXT(a_accept_starts_dots, in_valid && !in_stall, state_reg == S_DOT)
    `MNTD_ASSERT_IMP(a_seen_bounded, 1'b1, seen_reg <= CNT_W'(MAX_TRIANGLES))
    `MNTD_ASSERT_IMP(a_dots_scaled, state_reg == S_VMUL, dots_fit)
    `MNTD_ASSERT_IMP(a_weights_bounded, state_reg == S_CLOSE, (t_reg[0] <= T_ONE) && (t_reg[1] <= T_ONE))
    `MNTD_ASSERT_NEXT(a_emit_loads_output, emit_go, out_valid_reg && (state_reg == S_IDLE))

endmodule

`default_nettype wire

[test/mesh_nearest_triangle_distance_tb.sv]
// ----------------------------------------------------------------------------
// mesh_nearest_triangle_distance_tb
// Streams triangles against a configured query point and checks each nearest
// triangle result (index, squared distance, root, signed distance) against an
// in-bench fixed-point closest-point predictor. Random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module mesh_nearest_triangle_distance_tb;
    import mntd_pkg::*;

    localparam int WATCHDOG_LIMIT = 6000;
    localparam int SETTLE_CYCLES  = 300;
    localparam int HOLD_CYCLES    = 400;
    localparam logic signed [31:0] UNIT = 32'sh0001_0000;

    typedef struct {
        logic signed [31:0] v[3][3];
        logic signed [31:0] n[3];
    } triangle_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [63:0]      dsq;
        logic [31:0]      ud;
        logic [32:0]      sd;
    } nearest_t;

    class nearest_triangle_tracker;
        longint          query[3];
        int unsigned     tri_count;
        int unsigned     nrm_count;
        longint unsigned best_dsq;
        int unsigned     best_idx;
        bit              best_neg;
        int unsigned     seen;
        nearest_t        pending_nearest[$];
        int              mismatches;
        int              results;

        function new();
            query = '{0, 0, 0};
            tri_count = 1;
            nrm_count = 0;
            best_dsq = '1;
            best_idx = 0;
            best_neg = 0;
            seen = 0;
            mismatches = 0;
            results = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_QUERY_X:        query[0] = longint'($signed(data));
                CFG_QUERY_Y:        query[1] = longint'($signed(data));
                CFG_QUERY_Z:        query[2] = longint'($signed(data));
                CFG_TRIANGLE_COUNT: tri_count = data[12:0];
                CFG_NORMAL_COUNT:   nrm_count = data[12:0];
                default: ;
            endcase
        endfunction

        function longint unsigned magn(longint x);
            return x < 0 ? longint'(-x) : x;
        endfunction

        function longint dot4(longint x[3], longint y[3]);
            longint s;
            s = 0;
            for (int i = 0; i < 3; i++) s += (x[i] >>> 2) * (y[i] >>> 2);
            return s;
        endfunction

        function int fit_shift(longint v[6], longint unsigned lim);
            longint unsigned m;
            int k;
            m = 0;
            k = 0;
            for (int i = 0; i < 6; i++) if (magn(v[i]) > m) m = magn(v[i]);
            while ((m >> k) >= lim) k++;
            return k;
        endfunction

        function longint weight(longint num, longint den);
            if (den <= 0) return 0;
            if (num < 0) num = 0;
            if (num > den) num = den;
            while (den >= (64'sd1 <<< DEN_LIMIT_BIT)) begin
                num = num >>> 1;
                den = den >>> 1;
            end
            return (num <<< FRACTION_BITS) / den;
        endfunction

        function longint scale(longint comp, longint t);
            return (comp * t + (64'sd1 <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
        endfunction

        function longint unsigned root(longint unsigned x);
            longint unsigned r, b;
            r = 0;
            b = 64'd1 << 62;
            while (b > x) b >>= 2;
            while (b != 0) begin
                if (x >= r + b) begin
                    x -= r + b;
                    r = (r >> 1) + b;
                end else begin
                    r >>= 1;
                end
                b >>= 2;
            end
            return r;
        endfunction

        function void take_triangle(triangle_t t);
            longint a[3], b[3], c[3], nv[3], ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
            longint base[3], e1[3], e2[3], o[3], d[6], ov[6];
            longint t1, t2, va, vb, vc, orient, qc, sdv;
            longint unsigned dsq_acc, m, ud;
            bit sat;
            int k;
            int unsigned cnt;
            nearest_t r;
            t1 = 0;
            t2 = 0;
            for (int i = 0; i < 3; i++) begin
                a[i] = t.v[0][i];
                b[i] = t.v[1][i];
                c[i] = t.v[2][i];
                nv[i] = t.n[i];
                ab[i] = b[i] - a[i];
                ac[i] = c[i] - a[i];
                bc[i] = c[i] - b[i];
                ap[i] = query[i] - a[i];
                bp[i] = query[i] - b[i];
                cp[i] = query[i] - c[i];
                base[i] = a[i];
                e1[i] = ab[i];
                e2[i] = ac[i];
            end
            d[0] = dot4(ab, ap);
            d[1] = dot4(ac, ap);
            d[2] = dot4(ab, bp);
            d[3] = dot4(ac, bp);
            d[4] = dot4(ab, cp);
            d[5] = dot4(ac, cp);
            k = fit_shift(d, 64'd1 << DOT_LIMIT_BIT);
            for (int i = 0; i < 6; i++) d[i] = d[i] >>> k;
            vc = d[0] * d[3] - d[2] * d[1];
            vb = d[4] * d[1] - d[0] * d[5];
            va = d[2] * d[5] - d[4] * d[3];

            if (d[0] <= 0 && d[1] <= 0) begin
                // nearest to v0
            end else if (d[2] >= 0 && d[3] <= d[2]) begin
                base = b;
            end else if (vc <= 0 && d[0] >= 0 && d[2] <= 0) begin
                t1 = weight(d[0], d[0] - d[2]);
            end else if (d[5] >= 0 && d[4] <= d[5]) begin
                base = c;
            end else if (vb <= 0 && d[1] >= 0 && d[5] <= 0) begin
                t2 = weight(d[1], d[1] - d[5]);
            end else if (va <= 0 && (d[3] - d[2]) >= 0 && (d[4] - d[5]) >= 0) begin
                base = b;
                e1 = bc;
                t1 = weight(d[3] - d[2], (d[3] - d[2]) + (d[4] - d[5]));
            end else begin
                t1 = weight(vb, va + vb + vc);
                t2 = weight(vc, va + vb + vc);
            end

            dsq_acc = 0;
            sat = 0;
            for (int i = 0; i < 3; i++) begin
                qc = base[i] + scale(e1[i], t1) + scale(e2[i], t2);
                o[i] = query[i] - qc;
                m = magn(o[i]);
                if (m >= (64'd1 << 32)) sat = 1;
                else if (dsq_acc > ~64'd0 - m * m) sat = 1;
                else dsq_acc += m * m;
            end
            if (sat) dsq_acc = '1;

            ov = '{o[0], o[1], o[2], 0, 0, 0};
            k = fit_shift(ov, 64'd1 << ORIENT_LIMIT_BIT);
            orient = 0;
            for (int i = 0; i < 3; i++) orient += (o[i] >>> k) * nv[i];

            if (seen == 0 || dsq_acc < best_dsq) begin
                best_dsq = dsq_acc;
                best_idx = seen;
                best_neg = orient < 0;
            end
            seen++;

            cnt = tri_count;
            if (cnt < 1) cnt = 1;
            if (cnt > MAX_TRIANGLES) cnt = MAX_TRIANGLES;
            if (seen < cnt) return;

            ud = root(best_dsq);
            sdv = (best_idx < nrm_count && best_neg) ? -longint'(ud) : longint'(ud);
            r.idx = best_idx[IDX_W-1:0];
            r.dsq = best_dsq;
            r.ud = ud[31:0];
            r.sd = sdv[32:0];
            pending_nearest.push_back(r);
            best_dsq = '1;
            best_idx = 0;
            best_neg = 0;
            seen = 0;
        endfunction

        function void flag(string what, logic [63:0] exp_v, logic [63:0] act_v);
            if (mismatches < 10)
                $display("%0t: MISMATCH %s expected %h actual %h", $realtime, what, exp_v, act_v);
            mismatches++;
        endfunction

        function void compare_nearest(nearest_t act);
            nearest_t e;
            if (pending_nearest.size() == 0) begin
                flag("unexpected result, index", 0, act.idx);
                return;
            end
            e = pending_nearest.pop_front();
            results++;
            if (act.idx !== e.idx) flag("nearest_index", e.idx, act.idx);
            if (act.dsq !== e.dsq) flag("distance_squared", e.dsq, act.dsq);
            if (act.ud !== e.ud) flag("unsigned_distance", e.ud, act.ud);
            if (act.sd !== e.sd) flag("signed_distance", e.sd, act.sd);
        endfunction
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic signed [31:0]   v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z;
    logic signed [31:0]   normal_x, normal_y, normal_z;
    logic                 out_valid;
    logic                 out_stall;
    logic [IDX_W-1:0]     nearest_index;
    logic [63:0]          distance_squared;
    logic [31:0]          unsigned_distance;
    logic signed [32:0]   signed_distance;

    nearest_triangle_tracker tracker = new();
    bit idle_en = 1;
    bit hold_req = 0;
    int hold_cnt = 0;
    int sent = 0;
    int stall_cycles = 0;

    mesh_nearest_triangle_distance i_dut (.*);

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // receiver side
    always @(negedge clk) begin
        if (hold_req) begin
            hold_cnt = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_cnt > 0) begin
            hold_cnt--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= idle_en && ($urandom_range(0, 99) < 19);
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            tracker.compare_nearest({nearest_index, distance_squared,
                                     unsigned_distance, signed_distance});
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no progress", $realtime);
            $display("mesh_nearest_triangle_distance_tb: done, errors");
            $finish;
        end
    end

    // all tasks are entered and left just after a falling edge
    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        tracker.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_query(logic [31:0] qx, logic [31:0] qy, logic [31:0] qz,
                             logic [31:0] tc, logic [31:0] nc);
        cfg_write(CFG_QUERY_X, qx);
        cfg_write(CFG_QUERY_Y, qy);
        cfg_write(CFG_QUERY_Z, qz);
        cfg_write(CFG_TRIANGLE_COUNT, tc);
        cfg_write(CFG_NORMAL_COUNT, nc);
    endtask

    task automatic send_triangle(triangle_t t);
        int gap;
        gap = (idle_en && $urandom_range(0, 99) < 19) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        {v0_x, v0_y, v0_z} <= {t.v[0][0], t.v[0][1], t.v[0][2]};
        {v1_x, v1_y, v1_z} <= {t.v[1][0], t.v[1][1], t.v[1][2]};
        {v2_x, v2_y, v2_z} <= {t.v[2][0], t.v[2][1], t.v[2][2]};
        {normal_x, normal_y, normal_z} <= {t.n[0], t.n[1], t.n[2]};
        do @(posedge clk); while (in_stall);
        tracker.take_triangle(t);
        sent++;
        @(negedge clk);
    endtask

    // sender pause: every result in, then settle so a partial query is quiet
    task automatic wait_all_nearest();
        in_valid <= 1'b0;
        while (tracker.pending_nearest.size() != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // triangle (0,0,0) (4,0,0) (0,4,0) in units, placed so the query sits at p
    function automatic triangle_t local_tri(int px, int py, int pz, bit down);
        triangle_t t;
        int lx[3] = '{0, 4, 0};
        int ly[3] = '{0, 0, 4};
        for (int j = 0; j < 3; j++) begin
            t.v[j][0] = 32'(tracker.query[0]) + (lx[j] - px) * UNIT;
            t.v[j][1] = 32'(tracker.query[1]) + (ly[j] - py) * UNIT;
            t.v[j][2] = 32'(tracker.query[2]) - pz * UNIT;
        end
        t.n = '{0, 0, down ? -UNIT : UNIT};
        return t;
    endfunction

    function automatic triangle_t rand_tri();
        triangle_t t;
        int kind, spread;
        kind = $urandom_range(0, 99);
        spread = 1 << $urandom_range(8, 24);
        for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++)
                t.v[j][i] = (kind < 15) ? $urandom()
                          : 32'(tracker.query[i]) + $urandom_range(0, 2 * spread) - spread;
        if (kind >= 85 && kind < 92) t.v[2] = t.v[1];
        else if (kind >= 92) begin
            t.v[1] = t.v[0];
            t.v[2] = t.v[0];
        end
        for (int i = 0; i < 3; i++)
            t.n[i] = $urandom_range(0, 3) == 0 ? $urandom()
                   : $urandom_range(0, 2 * UNIT) - UNIT;
        return t;
    endfunction

    initial begin
        triangle_t t;
        int tc, nq;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_stall = 1'b0;
        {v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z} = '0;
        {normal_x, normal_y, normal_z} = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // region tests: vertices, edges, face both sides, degenerate shapes
        set_query(32'h0001_2345, 32'hFFFA_BCDF, 32'h0010_0000, 1, 1);
        send_triangle(local_tri(-1, -1, 1, 0));
        send_triangle(local_tri(6, -1, -1, 0));
        send_triangle(local_tri(-1, 6, 2, 1));
        send_triangle(local_tri(2, -1, 1, 0));
        send_triangle(local_tri(-1, 2, -1, 0));
        send_triangle(local_tri(3, 3, 1, 1));
        send_triangle(local_tri(1, 1, -2, 0));
        send_triangle(local_tri(1, 1, 2, 1));
        t = local_tri(1, 1, 1, 0);
        t.v[1] = t.v[0];
        t.v[2] = t.v[0];
        send_triangle(t);
        t = local_tri(1, 1, 1, 0);
        t.v[2] = t.v[1];
        send_triangle(t);
        wait_all_nearest();

        // ties go to the earliest triangle; third index is past the normal count
        cfg_write(CFG_TRIANGLE_COUNT, 3);
        cfg_write(CFG_NORMAL_COUNT, 2);
        send_triangle(local_tri(1, 1, 3, 1));
        send_triangle(local_tri(1, 1, -3, 1));
        send_triangle(local_tri(1, 1, 3, 0));
        send_triangle(local_tri(5, 5, 0, 1));
        send_triangle(local_tri(1, 1, -1, 0));
        send_triangle(local_tri(1, 1, 1, 0));
        wait_all_nearest();

        // extreme coordinates, saturation, oversized count lowered mid-query
        set_query(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 13'h1FFF, 13'h1FFF);
        for (int j = 0; j < 3; j++) begin
            t.v[j] = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF};
            t.n[j] = 32'sh8000_0000;
        end
        send_triangle(t);
        t.n = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF};
        t.v[1] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        send_triangle(t);
        t.v[0] = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000};
        send_triangle(t);
        wait_all_nearest();
        cfg_write(CFG_TRIANGLE_COUNT, 0);
        send_triangle(rand_tri());
        wait_all_nearest();

        // full output buffer: receiver holds off while triangles keep coming
        set_query($urandom(), $urandom(), $urandom(), 1, MAX_TRIANGLES);
        hold_req = 1;
        repeat (12) send_triangle(rand_tri());
        wait_all_nearest();

        nq = 0;
        while (sent < 530) begin
            tc = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
            idle_en = (nq != 3);
            if ($urandom_range(0, 4) == 0)
                set_query($urandom(), $urandom(), $urandom(), tc,
                          $urandom_range(0, 1) ? 0 : MAX_TRIANGLES);
            else
                set_query($urandom_range(0, 1 << 23) - (1 << 22),
                          $urandom_range(0, 1 << 23) - (1 << 22),
                          $urandom_range(0, 1 << 23) - (1 << 22),
                          tc, $urandom_range(0, tc + 1));
            repeat (tc * (idle_en ? $urandom_range(1, 4) : 60 / tc)) send_triangle(rand_tri());
            wait_all_nearest();
            nq++;
        end
        idle_en = 1;

        $display("triangles sent: %0d, nearest results checked: %0d, mismatches: %0d",
                 sent, tracker.results, tracker.mismatches);
        $display("covered all closest-point regions, saturation, clamped counts, back-pressure");
        if (tracker.mismatches == 0 && tracker.pending_nearest.size() == 0)
            $display("mesh_nearest_triangle_distance_tb: done, clean");
        else
            $display("mesh_nearest_triangle_distance_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
